// ===== src/slpm_pkg.sv =====
// Shared types, codes and byte helpers for the LIKE pattern matcher.
// No dependencies; used by slpm_ctrl, slpm_dp and sql_like_pattern_matcher.
package slpm_pkg;

  typedef enum logic [1:0] {
    CMD_PATTERN = 2'd0,
    CMD_VALUE   = 2'd1,
    CMD_EMPTY   = 2'd2
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FINISH
  } slpm_state_t;

  localparam logic [7:0] CH_PERCENT    = 8'h25;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;

  localparam logic REG_CASE = 1'b0;
  localparam logic REG_ESC  = 1'b1;

  typedef struct packed {
    logic accept;
    logic walk_init;
    logic eval;
    logic finish;
  } slpm_cmd_t;

  typedef struct packed {
    logic request;
    logic ovf_now;
    logic eval_done;
  } slpm_stat_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
      r = b - CH_UPPER_A + CH_LOWER_A;
    end
    return r;
  endfunction

  function automatic logic same_byte(input logic [7:0] x, input logic [7:0] y,
                                     input logic exact);
    logic r;
    if (exact) begin
      r = (x == y);
    end else begin
      r = (fold_byte(x) == fold_byte(y));
    end
    return r;
  endfunction

endpackage

// ===== src/slpm_ctrl.sv =====
// Controller FSM: takes items, sequences the match walk, hands off the result.
// Depends on slpm_pkg.
module slpm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_free,
  input  slpm_pkg::slpm_stat_t stat,
  output slpm_pkg::slpm_cmd_t  cmd
);
  import slpm_pkg::*;

  slpm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.accept    = in_valid;
        cmd.walk_init = in_valid && stat.request;
        if (cmd.walk_init) begin
          state_next = stat.ovf_now ? ST_FINISH : ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = stat.eval_done ? ST_FINISH : ST_READ;
      end
      ST_FINISH: begin
        cmd.finish = out_free;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/slpm_dp.sv =====
// Datapath: pattern and value stores, counts, overflow flags, match walk pointers.
// Depends on slpm_pkg; driven by slpm_ctrl commands.
module slpm_dp #(
  parameter int PATTERN_DEPTH = 64,
  parameter int VALUE_DEPTH   = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           command,
  input  logic [7:0]           data_byte,
  input  logic                 first,
  input  logic                 last,
  input  logic                 exact_cmp,
  input  logic                 esc_en,
  input  slpm_pkg::slpm_cmd_t  cmd,
  output slpm_pkg::slpm_stat_t stat,
  output logic                 hit,
  output logic                 ovf_hold
);
  import slpm_pkg::*;

  localparam int PCW = $clog2(PATTERN_DEPTH + 1);
  localparam int VCW = $clog2(VALUE_DEPTH + 1);
  localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int VAW = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;
  localparam logic [PCW-1:0] PD = PCW'(PATTERN_DEPTH);
  localparam logic [VCW-1:0] VD = VCW'(VALUE_DEPTH);

  logic [7:0] pat_mem [PATTERN_DEPTH];
  logic [7:0] val_mem [VALUE_DEPTH];

  logic [PCW-1:0] pcount, p, rp;
  logic [VCW-1:0] vcount, v, rv;
  logic           ptl, vtl, hr;
  logic [7:0]     pb, pb1, vb;

  logic [PCW-1:0] pidx, p1, p2, np;
  logic           pat_wr, val_wr;
  logic           p_lt, is_pct, esc, fits;
  logic [7:0]     cb;
  logic           done_now, hit_now;
  logic [PCW-1:0] p_next, rp_next;
  logic [VCW-1:0] v_next, rv_next;
  logic           hr_next;

  assign pidx   = first ? '0 : pcount;
  assign pat_wr = cmd.accept && (command == CMD_PATTERN) && (pidx < PD);
  assign val_wr = cmd.accept && (command == CMD_VALUE) && (vcount < VD);

  assign stat.request = (command == CMD_EMPTY) || ((command == CMD_VALUE) && last);
  assign stat.ovf_now = ptl || vtl || ((command == CMD_VALUE) && (vcount == VD));

  always_ff @(posedge clk) begin
    if (pat_wr) begin
      pat_mem[pidx[PAW-1:0]] <= data_byte;
    end
    if (val_wr) begin
      val_mem[vcount[VAW-1:0]] <= data_byte;
    end
    pb  <= pat_mem[p[PAW-1:0]];
    pb1 <= pat_mem[p1[PAW-1:0]];
    vb  <= val_mem[v[VAW-1:0]];
  end

  // one step of the greedy walk with a single retry point
  always_comb begin
    p1      = p + PCW'(1);
    p2      = p + PCW'(2);
    p_lt    = p < pcount;
    is_pct  = p_lt && (pb == CH_PERCENT);
    esc     = esc_en && (pb == CH_BACKSLASH) && (p1 < pcount);
    cb      = esc ? pb1 : pb;
    fits    = p_lt && ((pb == CH_UNDERSCORE) || same_byte(cb, vb, exact_cmp));
    np      = (esc && pb != CH_UNDERSCORE) ? p2 : p1;
    done_now = 1'b0;
    hit_now  = 1'b0;
    p_next   = p;
    v_next   = v;
    rp_next  = rp;
    rv_next  = rv;
    hr_next  = hr;
    if (v < vcount) begin
      if (is_pct) begin
        if (p1 == pcount) begin
          done_now = 1'b1;
          hit_now  = 1'b1;
        end else begin
          p_next  = p1;
          rp_next = p1;
          rv_next = v;
          hr_next = 1'b1;
        end
      end else if (fits) begin
        p_next = np;
        v_next = v + VCW'(1);
      end else if (!hr || rv >= vcount) begin
        done_now = 1'b1;
      end else begin
        rv_next = rv + VCW'(1);
        v_next  = rv + VCW'(1);
        p_next  = rp;
      end
    end else begin
      if (is_pct) begin
        if (p1 == pcount) begin
          done_now = 1'b1;
          hit_now  = 1'b1;
        end else begin
          p_next = p1;
        end
      end else begin
        done_now = 1'b1;
        hit_now  = (p == pcount);
      end
    end
  end

  assign stat.eval_done = done_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      pcount   <= '0;
      ptl      <= 1'b0;
      vcount   <= '0;
      vtl      <= 1'b0;
      ovf_hold <= 1'b0;
      hit      <= 1'b0;
      hr       <= 1'b0;
      p        <= '0;
      v        <= '0;
      rp       <= '0;
      rv       <= '0;
    end else begin
      if (cmd.accept) begin
        case (command)
          CMD_PATTERN: begin
            if (pidx < PD) begin
              pcount <= pidx + PCW'(1);
              ptl    <= first ? 1'b0 : ptl;
            end else begin
              pcount <= pidx;
              ptl    <= 1'b1;
            end
          end
          CMD_VALUE: begin
            if (vcount < VD) begin
              vcount <= vcount + VCW'(1);
            end else begin
              vtl <= 1'b1;
            end
          end
          CMD_EMPTY: begin
            vcount <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.walk_init) begin
        ovf_hold <= stat.ovf_now;
        hit      <= 1'b0;
        hr       <= 1'b0;
        p        <= '0;
        v        <= '0;
        rp       <= '0;
        rv       <= '0;
      end
      if (cmd.eval) begin
        p  <= p_next;
        v  <= v_next;
        rp <= rp_next;
        rv <= rv_next;
        hr <= hr_next;
        if (done_now) begin
          hit <= hit_now;
        end
      end
      if (cmd.finish) begin
        vcount <= '0;
        vtl    <= 1'b0;
      end
    end
  end

endmodule

// ===== src/sql_like_pattern_matcher.sv =====
// Top level of the SQL LIKE pattern matcher: APB registers, output register,
// controller and datapath. Depends on slpm_pkg, slpm_ctrl, slpm_dp.
//
//  channel | signals                                   | moves
//  in      | in_valid/in_ready, command..last          | one pattern or value item
//  out     | out_valid/out_ready, matched, overflow    | one result per value end
//  cfg     | psel/penable/pwrite/paddr/pwdata/prdata   | compare mode, escapes
//
// Pattern items and value items that do not end a value are taken while the
// controller stays idle. An item that ends a value starts the match walk: each
// step reads the stores through their registered read ports, then evaluates;
// the step count grows with value length times pattern length at worst.
// An overflowed value skips the walk. Reset clears counts and flags; store
// contents stay unknown. The result waits in an output register, and the walk
// holds in its finish state while that register is still full.
module sql_like_pattern_matcher #(
  parameter int PATTERN_DEPTH = 64,
  parameter int VALUE_DEPTH   = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  data_byte,
  input  logic        first,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        matched,
  output logic        overflow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import slpm_pkg::*;

  logic       exact_cmp, esc_en;
  logic       out_free, hit, ovf_hold;
  slpm_cmd_t  cmd;
  slpm_stat_t stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      exact_cmp <= 1'b1;
      esc_en    <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_CASE) begin
        exact_cmp <= pwdata[0];
      end else begin
        esc_en <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_ESC) ? {31'd0, esc_en}
                                        : {31'd0, exact_cmp};

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      matched  <= hit && !ovf_hold;
      overflow <= ovf_hold;
    end
  end

  slpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd)
  );

  slpm_dp #(
    .PATTERN_DEPTH (PATTERN_DEPTH),
    .VALUE_DEPTH   (VALUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .command   (command),
    .data_byte (data_byte),
    .first     (first),
    .last      (last),
    .exact_cmp (exact_cmp),
    .esc_en    (esc_en),
    .cmd       (cmd),
    .stat      (stat),
    .hit       (hit),
    .ovf_hold  (ovf_hold)
  );

  a_ovf_no_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(matched && overflow))
    else $error("overflow result reports a match");

  a_busy_after_end: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && ((command == CMD_EMPTY) || ((command == CMD_VALUE) && last)))
    |=> !in_ready)
    else $error("input still ready after a value end");

  a_result_from_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a match walk");

endmodule
